/* design/life_generation_row_engine_unit_assert.svh */
// Assertion macros used by the checker of the Life row engine.
`ifndef LIFE_GENERATION_ROW_ENGINE_UNIT_ASSERT_SVH
`define LIFE_GENERATION_ROW_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define LGRE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and masked during reset.
`define LGRE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/lgre_pkg.sv */
// Shared types and constants of the Life generation row engine.
package lgre_pkg;

  localparam int ROW_W       = 64;
  localparam int COL_W       = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [COL_W-1:0] COLUMNS_RESET = 7'd64;

  // Bits one column shows to its neighbors: its two held bits and its row bit.
  typedef struct packed {
    logic upper;
    logic middle;
    logic row;
  } lgre_nbr_t;

  localparam lgre_nbr_t NBR_DEAD = '{upper: 1'b0, middle: 1'b0, row: 1'b0};

  // Update strobes from the top level to every column.
  typedef struct packed {
    logic load;
    logic clear;
  } lgre_cell_ctl_t;

  // One queued result item.
  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic             final_flag;
  } lgre_result_t;

  // Results produced by one accepted row, in delivery order.
  typedef struct packed {
    logic             first_vld;
    logic [ROW_W-1:0] first_cells;
    logic             second_vld;
    logic [ROW_W-1:0] second_cells;
  } lgre_push_t;

endpackage

/* design/lgre_cell.sv */
// One column of the row engine: holds two grid bits and applies rule B3/S23.
module lgre_cell
  import lgre_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  lgre_cell_ctl_t ctl,
  input  logic           row_bit,
  input  logic           col_en,
  input  lgre_nbr_t      left,
  input  lgre_nbr_t      right,
  output lgre_nbr_t      here,
  output logic           gen_above,
  output logic           gen_bottom
);

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  logic upper;
  logic middle;
  logic row_m;
  logic [3:0] n_above;
  logic [3:0] n_bottom;

  function automatic logic life_rule(input logic alive, input logic [3:0] n);
    life_rule = (n == BIRTH_COUNT) || (alive && (n == SURVIVE_COUNT));
  endfunction

  assign row_m = row_bit & col_en;
  assign here  = '{upper: upper, middle: middle, row: row_m};

  // The held middle row is judged with the arriving row below it.
  assign n_above = 4'(left.upper) + 4'(upper) + 4'(right.upper)
                 + 4'(left.middle) + 4'(right.middle)
                 + 4'(left.row) + 4'(row_m) + 4'(right.row);

  // The arriving row is judged with a dead row below it.
  assign n_bottom = 4'(left.middle) + 4'(middle) + 4'(right.middle)
                  + 4'(left.row) + 4'(right.row);

  assign gen_above  = col_en & life_rule(middle, n_above);
  assign gen_bottom = col_en & life_rule(row_m, n_bottom);

  always_ff @(posedge clk) begin
    if (rst) begin
      upper  <= 1'b0;
      middle <= 1'b0;
    end else if (ctl.load) begin
      if (ctl.clear) begin
        upper  <= 1'b0;
        middle <= 1'b0;
      end else begin
        upper  <= middle;
        middle <= row_m;
      end
    end
  end

endmodule

/* design/lgre_out_queue.sv */
// Result queue that takes up to two items per cycle and hands out one unless stalled.
module lgre_out_queue
  import lgre_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lgre_push_t       push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] next_row_cells,
  output logic             final_row
);

  lgre_result_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QPTR_W-1:0] second_ptr;
  logic [QCNT_W-1:0] push_n;
  logic pop;

  assign out_valid      = count != '0;
  assign pop            = out_valid && !out_stall;
  // Room for the two items a bottom row can bring.
  assign room           = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign next_row_cells = mem[rd_ptr].cells;
  assign final_row      = mem[rd_ptr].final_flag;
  assign second_ptr     = wr_ptr + QPTR_W'(push.first_vld);
  assign push_n         = QCNT_W'(push.first_vld) + QCNT_W'(push.second_vld);

  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      mem[wr_ptr] <= '{cells: push.first_cells, final_flag: 1'b0};
    end
    if (push.second_vld) begin
      mem[second_ptr] <= '{cells: push.second_cells, final_flag: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + push_n - QCNT_W'(pop);
    end
  end

endmodule

/* design/life_generation_row_engine_unit.sv */
// Top level of the streaming Life (B3/S23) one-generation row engine.
//
// The grid streams in one row per item, top to bottom, with last_row set on
// the bottom row; cells left of column 0, at or beyond the column count, above
// the top row and below the bottom row count as dead. A row of identical
// column cells holds the two most recent rows, and each cell reads the held
// and arriving bits of its two neighbors, so a whole row's next generation is
// formed combinationally. Every row after the first yields the next generation
// of the row above it; the bottom row additionally yields its own, flagged
// with final_row. A grid of one row yields a single flagged item. Results go
// through a four-item queue: one row is taken per clock while in_stall is low;
// a row's results are queued in the cycle after it is taken. A bottom row puts two
// items in the queue, but a grid of n rows yields only n items, so while the
// output side takes one item per clock the queue never holds more than two
// and rows flow with no gap. The input stalls only while the queue holds more
// than two items, which happens only when the output side stalls. The column
// count is written on the cfg port (always ready) while the block is idle, a
// user rule the block does not enforce; values above MAX_COLUMNS saturate,
// zero makes every output row dead; output bits from MAX_COLUMNS up are always 0.
module life_generation_row_engine_unit
  import lgre_pkg::*;
#(
  parameter int MAX_COLUMNS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ROW_W-1:0] row_cells,
  input  logic             last_row,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] next_row_cells,
  output logic             final_row,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [COL_W-1:0] columns_in_use
);

  logic [COL_W-1:0] columns;
  logic             middle_valid;
  logic             room;
  logic             accept;
  lgre_cell_ctl_t   ctl;
  lgre_push_t       push;
  lgre_nbr_t        here_bits [MAX_COLUMNS];
  logic [ROW_W-1:0] gen_above;
  logic [ROW_W-1:0] gen_bottom;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room;
  assign accept    = in_valid && !in_stall;
  assign ctl       = '{load: accept, clear: last_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLUMNS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      columns <= columns_in_use;
    end
  end

  // Set while a row whose next generation is still owed sits in the cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      middle_valid <= 1'b0;
    end else if (accept) begin
      middle_valid <= !last_row;
    end
  end

  for (genvar j = 0; j < ROW_W; j++) begin : g_col
    if (j < MAX_COLUMNS) begin : g_live
      lgre_nbr_t left_n;
      lgre_nbr_t right_n;
      logic      col_en;

      assign col_en = columns > COL_W'(j);

      if (j == 0) begin : g_left_edge
        assign left_n = NBR_DEAD;
      end else begin : g_left_inner
        assign left_n = here_bits[j-1];
      end

      if (j == MAX_COLUMNS - 1) begin : g_right_edge
        assign right_n = NBR_DEAD;
      end else begin : g_right_inner
        assign right_n = here_bits[j+1];
      end

      lgre_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .row_bit   (row_cells[j]),
        .col_en    (col_en),
        .left      (left_n),
        .right     (right_n),
        .here      (here_bits[j]),
        .gen_above (gen_above[j]),
        .gen_bottom(gen_bottom[j])
      );
    end else begin : g_dead
      assign gen_above[j]  = 1'b0;
      assign gen_bottom[j] = 1'b0;
    end
  end

  assign push = '{
    first_vld:    accept && middle_valid,
    first_cells:  gen_above,
    second_vld:   accept && last_row,
    second_cells: gen_bottom
  };

  lgre_out_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .room          (room),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .next_row_cells(next_row_cells),
    .final_row     (final_row)
  );

endmodule

/* design/lgre_checker.sv */
// Port-level checker for the Life row engine, bound to its top level.
`include "life_generation_row_engine_unit_assert.svh"

module lgre_checker
  import lgre_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             last_row,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ROW_W-1:0] next_row_cells,
  input logic             final_row,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  logic           out_held;
  logic [ROW_W:0] out_item;
  logic           last_take;

  assign out_held  = out_valid && out_stall;
  assign out_item  = {next_row_cells, final_row};
  assign last_take = in_valid && !in_stall && last_row;

  // A held result item must not change or vanish.
  `LGRE_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_item), "held item changed")

  // A bottom row always leaves at least one result waiting.
  `LGRE_ASSERT_NEXT(a_last_gives_out, last_take, out_valid, "bottom row gave no item")

  // With nothing queued the input side must be open.
  `LGRE_ASSERT_NOW(a_empty_no_stall, !out_valid, !in_stall, "input stalled while empty")

  // The register port never holds off a write.
  `LGRE_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "column count write was held off")

endmodule

bind life_generation_row_engine_unit lgre_checker u_lgre_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .last_row      (last_row),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .next_row_cells(next_row_cells),
  .final_row     (final_row),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
